// ===== src/bzr_pkg.sv =====
// Package for the buzzer tone pattern sequencer: field widths, item codes,
// the sequencer state type and the fixed phase tables of both patterns.
// Depends on nothing; used by bzr_step and the top level.
`default_nettype none

package bzr_pkg;

    localparam int FREQ_W = 12;
    localparam int DUR_W  = 9;
    localparam int IDX_W  = 3;
    localparam int DUTY_W = 8;
    localparam int PAT_W  = 2;

    // Item codes
    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_START = 1'b1;

    // Pattern codes
    localparam logic [PAT_W-1:0] PAT_BEEPS = 2'd1;
    localparam logic [PAT_W-1:0] PAT_TONES = 2'd2;

    // Pattern lengths in phases
    localparam logic [IDX_W-1:0] BEEPS_LEN = 3'd3;
    localparam logic [IDX_W-1:0] TONES_LEN = 3'd7;
    localparam logic [IDX_W-1:0] EMPTY_LEN = 3'd0;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
        logic              on;
    } phase_t;

    typedef struct packed {
        logic              active;
        logic [PAT_W-1:0]  pattern;
        logic [IDX_W-1:0]  phase_index;
        logic [DUR_W-1:0]  remaining_ms;
        logic [FREQ_W-1:0] tone_now;
        logic [DUTY_W-1:0] duty_now;
    } seq_state_t;

    // Number of phases in a pattern; unknown patterns are empty
    function automatic logic [IDX_W-1:0] pattern_length(input logic [PAT_W-1:0] pat);
        logic [IDX_W-1:0] len;
        case (pat)
            PAT_BEEPS: len = BEEPS_LEN;
            PAT_TONES: len = TONES_LEN;
            default:   len = EMPTY_LEN;
        endcase
        return len;
    endfunction

    // Phase table: two beeps, or four rising tones with gaps
    function automatic phase_t phase_lookup(input logic [PAT_W-1:0] pat,
                                            input logic [IDX_W-1:0] idx);
        phase_t ph;
        if (pat == PAT_BEEPS) begin
            case (idx)
                3'd0:    ph = '{freq: 12'd2400, dur: 9'd110, on: 1'b1};
                3'd1:    ph = '{freq: 12'd0,    dur: 9'd80,  on: 1'b0};
                3'd2:    ph = '{freq: 12'd2400, dur: 9'd110, on: 1'b1};
                default: ph = '0;
            endcase
        end
        else begin
            case (idx)
                3'd0:    ph = '{freq: 12'd1800, dur: 9'd220, on: 1'b1};
                3'd1:    ph = '{freq: 12'd0,    dur: 9'd120, on: 1'b0};
                3'd2:    ph = '{freq: 12'd2200, dur: 9'd220, on: 1'b1};
                3'd3:    ph = '{freq: 12'd0,    dur: 9'd120, on: 1'b0};
                3'd4:    ph = '{freq: 12'd2600, dur: 9'd220, on: 1'b1};
                3'd5:    ph = '{freq: 12'd0,    dur: 9'd120, on: 1'b0};
                3'd6:    ph = '{freq: 12'd3000, dur: 9'd260, on: 1'b1};
                default: ph = '0;
            endcase
        end
        return ph;
    endfunction

endpackage

`default_nettype wire

// ===== src/bzr_step.sv =====
// Next-state logic of the buzzer sequencer for one item (start or tick).
// Depends on bzr_pkg for the state type, item codes and phase tables.
`default_nettype none

module bzr_step (
    input  wire bzr_pkg::seq_state_t                  state_cur,
    input  wire                                       action,
    input  wire [bzr_pkg::PAT_W-1:0]                  pattern,
    input  wire [bzr_pkg::DUTY_W-1:0]                 on_duty,
    output bzr_pkg::seq_state_t                       state_next
);

    bzr_pkg::phase_t             ph;
    logic [bzr_pkg::DUR_W-1:0]   rem_dec;
    logic [bzr_pkg::IDX_W-1:0]   len;

    // Table lookup for the current phase
    assign ph      = bzr_pkg::phase_lookup(state_cur.pattern, state_cur.phase_index);
    assign len     = bzr_pkg::pattern_length(state_cur.pattern);
    assign rem_dec = state_cur.remaining_ms - 1'b1;

    // Start arms phase 0; tick counts down, advances on expiry, idles at the end
    always_comb
    begin
        state_next = state_cur;
        if (action == bzr_pkg::ACTION_START) begin
            state_next.active       = 1'b1;
            state_next.pattern      = pattern;
            state_next.phase_index  = '0;
            state_next.remaining_ms = '0;
        end
        else if (state_cur.active) begin
            if (state_cur.remaining_ms != '0 && rem_dec != '0) begin
                state_next.remaining_ms = rem_dec;
            end
            else if (state_cur.phase_index >= len) begin
                // pattern finished: go idle and silent
                state_next = '0;
            end
            else begin
                state_next.tone_now     = ph.on ? ph.freq : '0;
                state_next.duty_now     = ph.on ? on_duty : '0;
                state_next.remaining_ms = ph.dur;
                state_next.phase_index  = state_cur.phase_index + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/buzzer_tone_pattern_sequencer.sv =====
// Buzzer tone pattern sequencer, top level: state and result registers,
// handshakes and the on_duty register. Depends on bzr_pkg and bzr_step.
//
// Usage:
//   Input channel (in_valid / in_stall, fields action and pattern): a start
//   item (action = 1) arms pattern 1 (two beeps) or 2 (four rising tones) at
//   phase 0; a tick item (action = 0) stands for one millisecond and counts
//   the current phase down, loading the next phase when it runs out.
//   Output channel (out_valid / out_stall): exactly one result per item with
//   tone_freq_hz, duty and busy_res as they stand after that item.
//   Config channel (cfg_valid / cfg_ready, cfg_data): writes on_duty, the duty
//   used by tone phases; write only while no item is in flight.
//   The result of an item is registered and valid the cycle after acceptance.
//   Throughput: one item per cycle while no result waits, set by the single
//   result register holding one item while next-state logic works on the next.
//   Stall: while a result waits with out_stall high, in_stall is raised and
//   the waiting result holds. Reset: idle, silent, on_duty = 128, no result.
`default_nettype none

module buzzer_tone_pattern_sequencer (
    input  wire                             clk,
    input  wire                             rst_n,
    // input items
    input  wire                             in_valid,
    output logic                            in_stall,
    input  wire                             action,
    input  wire [bzr_pkg::PAT_W-1:0]        pattern,
    // result items
    output logic                            out_valid,
    input  wire                             out_stall,
    output logic [bzr_pkg::FREQ_W-1:0]      tone_freq_hz,
    output logic [bzr_pkg::DUTY_W-1:0]      duty,
    output logic                            busy_res,
    // configuration
    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [bzr_pkg::DUTY_W-1:0]       cfg_data
);

    bzr_pkg::seq_state_t              state_reg;
    bzr_pkg::seq_state_t              state_next;
    logic [bzr_pkg::DUTY_W-1:0]       on_duty_reg;
    logic                             out_valid_reg;
    logic [bzr_pkg::FREQ_W-1:0]       tone_reg;
    logic [bzr_pkg::DUTY_W-1:0]       duty_reg;
    logic                             busy_reg;
    logic                             in_accept;

    // Handshakes
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    bzr_step u_step (
        .state_cur  (state_reg),
        .action     (action),
        .pattern    (pattern),
        .on_duty    (on_duty_reg),
        .state_next (state_next)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            on_duty_reg <= 8'd128;
        end
        else if (cfg_valid && cfg_ready) begin
            on_duty_reg <= cfg_data;
        end
    end

    // Sequencer state, updated once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end
        else if (in_accept) begin
            state_reg <= state_next;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            tone_reg <= state_next.tone_now;
            duty_reg <= state_next.duty_now;
            busy_reg <= state_next.active;
        end
    end

    assign out_valid    = out_valid_reg;
    assign tone_freq_hz = tone_reg;
    assign duty         = duty_reg;
    assign busy_res     = busy_reg;

    // Idle results are silent
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !busy_res |-> tone_freq_hz == '0 && duty == '0)
        else $error("idle result carries a tone");

    // An idle sequencer holds no phase progress
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.active |-> state_reg.phase_index == '0 && state_reg.remaining_ms == '0)
        else $error("idle state not cleared");

    // A start item yields a busy result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && action == bzr_pkg::ACTION_START |=> out_valid && busy_res)
        else $error("start item did not give busy result");

    // Phase durations never exceed the longest table entry
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.remaining_ms <= 9'd260)
        else $error("remaining time out of range");

    // Input is only held off by a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("stall without pending result");

endmodule

`default_nettype wire
